// ===== rtl/bdt_pkg.sv =====
package bdt_pkg;

   // Payload field widths
   localparam int OP_W       = 2;
   localparam int NOW_W      = 48;
   localparam int QUEUE_W    = 16;
   localparam int STA_W      = 24;
   localparam int RETRY_W    = 32;
   localparam int NODE_W     = 32;
   localparam int DELAY_W    = 11;
   localparam int SLOT_W     = 2;
   localparam int NSLOTS     = 3;

   // Configuration registers
   localparam int EPS_W      = 16;
   localparam int BPS_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPS = 1'b1;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd128;
   localparam logic [BPS_W-1:0] BPS_RESET = 32'd8192;

   // Opcodes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_NODE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // Slot indexes
   localparam logic [SLOT_W-1:0] SLOT_QUEUE = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_RETRY = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_NODE  = 2'd2;

   // Delay arithmetic
   localparam logic [DELAY_W-1:0] DELAY_CAP = 11'd1024;
   localparam int PROD_W     = 40;           // split_time_avg * queue_size
   localparam int DUR_W      = 31;           // ceil(product / 512)
   localparam int DUR_SHIFT  = 9;
   localparam logic [PROD_W-1:0] DUR_ROUND = 40'd511;
   localparam int QREC_W     = 32;           // queue_size * reciprocal of ten
   localparam logic [QUEUE_W-1:0] Q_RECIP = 16'd52429;
   localparam int Q_SHIFT    = 19;
   localparam int Q10_W      = QREC_W - Q_SHIFT;
   localparam logic [Q10_W-1:0] Q10_MIN  = 13'd5;
   localparam logic [Q10_W-1:0] Q10_BIAS = 13'd4;
   localparam logic [RETRY_W-1:0] RETRY_MIN = 32'd500;
   localparam logic [RETRY_W-1:0] RETRY_CAP = 32'd100400;
   localparam int RETRY_STEPS = 9;
   localparam int DIV_STEPS_W = 5;           // 32 quotient bits, one per cycle

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_WR,
      ST_DIV,
      ST_NODE_WR,
      ST_QUERY
   } bdt_state_type;

   typedef struct packed {
      logic capture;
      logic mul_en;
      logic load_wr;
      logic div_step;
      logic node_wr;
      logic rsp_load;
   } bdt_cmd_type;

   typedef struct packed {
      logic div_last;
      logic rsp_busy;
   } bdt_sts_type;

   // 2^k, saturating at the cap for k >= 10
   function automatic logic [DELAY_W-1:0] pow2_capped(input logic [Q10_W-1:0] k);
      if (k < Q10_W'(10)) begin
         return DELAY_W'(1) << k[3:0];
      end
      return DELAY_CAP;
   endfunction

   // Node ratio delay: 0 below 2, 2^(m-2) below 12, then the cap
   function automatic logic [DELAY_W-1:0] ratio_delay(input logic [NODE_W-1:0] m);
      if (m < NODE_W'(2)) begin
         return '0;
      end
      if (m < NODE_W'(12)) begin
         return DELAY_W'(1) << (m[3:0] - 4'd2);
      end
      return DELAY_CAP;
   endfunction

   // Retry delay: exponent is (retry/100 - 4)/100, found by threshold compares
   function automatic logic [DELAY_W-1:0] retry_delay(input logic [RETRY_W-1:0] r);
      logic [3:0] k;
      k = '0;
      if (r < RETRY_MIN) begin
         return '0;
      end
      if (r >= RETRY_CAP) begin
         return DELAY_CAP;
      end
      for (int j = 1; j <= RETRY_STEPS; j++) begin
         if (r >= RETRY_W'(400 + 10000 * j)) begin
            k = k + 4'd1;
         end
      end
      return DELAY_W'(1) << k;
   endfunction

endpackage

// ===== rtl/bdt_ifs.sv =====
interface bdt_req_if;
   import bdt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      opcode;
   logic [NOW_W-1:0]     now_ms;
   logic [QUEUE_W-1:0]   queue_size;
   logic [STA_W-1:0]     split_time_avg;
   logic [RETRY_W-1:0]   retry_ms;
   logic [NODE_W-1:0]    node_elements;
   logic [NODE_W-1:0]    node_bytes;

   modport source (output valid, opcode, now_ms, queue_size, split_time_avg, retry_ms,
                   node_elements, node_bytes, input ready);
   modport sink (input valid, opcode, now_ms, queue_size, split_time_avg, retry_ms,
                 node_elements, node_bytes, output ready);
endinterface

interface bdt_rsp_if;
   import bdt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DELAY_W-1:0]   current_delay;
   logic [SLOT_W-1:0]    winning_slot;

   modport source (output valid, current_delay, winning_slot, input ready);
   modport sink (input valid, current_delay, winning_slot, output ready);
endinterface

// ===== rtl/bdt_ctrl.sv =====
module bdt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [bdt_pkg::OP_W-1:0] req_opcode,
   output logic                     req_ready,
   input  bdt_pkg::bdt_sts_type     sts,
   output bdt_pkg::bdt_cmd_type     cmd
);
   import bdt_pkg::*;

   bdt_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_opcode)
                  OP_LOAD:  state_in = ST_LOAD_MUL;
                  OP_NODE:  state_in = ST_DIV;
                  OP_QUERY: state_in = ST_QUERY;
                  default:  state_in = ST_IDLE;   // unused opcode: dropped
               endcase
            end
         end
         ST_LOAD_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_NODE_WR;
            end
         end
         ST_NODE_WR: begin
            cmd.node_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_QUERY: begin
            // wait for the output register to free up
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bdt_dp.sv =====
module bdt_dp #(
   parameter int TIME_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bdt_pkg::bdt_cmd_type          cmd,
   output bdt_pkg::bdt_sts_type          sts,
   input  logic [bdt_pkg::NOW_W-1:0]     req_now_ms,
   input  logic [bdt_pkg::QUEUE_W-1:0]   req_queue_size,
   input  logic [bdt_pkg::STA_W-1:0]     req_split_time_avg,
   input  logic [bdt_pkg::RETRY_W-1:0]   req_retry_ms,
   input  logic [bdt_pkg::NODE_W-1:0]    req_node_elements,
   input  logic [bdt_pkg::NODE_W-1:0]    req_node_bytes,
   input  logic                          csr_we,
   input  logic [bdt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bdt_pkg::DELAY_W-1:0]   rsp_current_delay,
   output logic [bdt_pkg::SLOT_W-1:0]    rsp_winning_slot
);
   import bdt_pkg::*;

   localparam int EXP_W = TIME_BITS + 1;

   // Configuration registers
   logic [EPS_W-1:0] eps_ff;
   logic [BPS_W-1:0] bps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
         bps_ff <= BPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EPS: eps_ff <= csr_wdata[EPS_W-1:0];
            CSR_BPS: bps_ff <= csr_wdata[BPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input word capture; time is cut or widened to TIME_BITS
   logic [NOW_W+TIME_BITS-1:0] now_ext;
   logic [TIME_BITS-1:0]       now_ff;
   logic [EXP_W-1:0]           now_wide;
   logic [QUEUE_W-1:0]         queue_ff;
   logic [STA_W-1:0]           sta_ff;
   logic [RETRY_W-1:0]         retry_ff;

   assign now_ext  = {{TIME_BITS{1'b0}}, req_now_ms};
   assign now_wide = {1'b0, now_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff   <= now_ext[TIME_BITS-1:0];
         queue_ff <= req_queue_size;
         sta_ff   <= req_split_time_avg;
         retry_ff <= req_retry_ms;
      end
   end

   // Load report products
   logic [QREC_W-1:0] qrec_ff;
   logic [PROD_W-1:0] dprod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         qrec_ff  <= QREC_W'(queue_ff) * QREC_W'(Q_RECIP);
         dprod_ff <= PROD_W'(sta_ff) * PROD_W'(queue_ff);
      end
   end

   logic [Q10_W-1:0]   q10;
   logic [PROD_W-1:0]  dround;
   logic [DUR_W-1:0]   dur0;
   logic [DELAY_W-1:0] d0, d1;
   logic [EXP_W-1:0]   exp0, exp1;

   always_comb begin
      q10    = qrec_ff[QREC_W-1:Q_SHIFT];
      dround = dprod_ff + DUR_ROUND;
      d0     = '0;
      dur0   = '0;
      if (q10 >= Q10_MIN) begin
         d0   = pow2_capped(q10 - Q10_BIAS);
         dur0 = dround[PROD_W-1:DUR_SHIFT];
      end
      d1   = retry_delay(retry_ff);
      exp0 = now_wide + EXP_W'(dur0);
      exp1 = now_wide + EXP_W'({d1, 1'b0});
   end

   // Two restoring dividers, one quotient bit per cycle each
   logic [EPS_W-1:0]  rem_e_ff, rem_e_in;
   logic [NODE_W-1:0] quo_e_ff, quo_e_in;
   logic [BPS_W-1:0]  rem_b_ff, rem_b_in;
   logic [NODE_W-1:0] quo_b_ff, quo_b_in;
   logic [EPS_W:0]    sh_e, diff_e;
   logic [BPS_W:0]    sh_b, diff_b;
   logic              ge_e, ge_b;
   logic [DIV_STEPS_W-1:0] div_cnt_ff;

   always_comb begin
      sh_e     = {rem_e_ff, quo_e_ff[NODE_W-1]};
      diff_e   = sh_e - {1'b0, eps_ff};
      ge_e     = sh_e >= {1'b0, eps_ff};
      rem_e_in = ge_e ? diff_e[EPS_W-1:0] : sh_e[EPS_W-1:0];
      quo_e_in = {quo_e_ff[NODE_W-2:0], ge_e};
      sh_b     = {rem_b_ff, quo_b_ff[NODE_W-1]};
      diff_b   = sh_b - {1'b0, bps_ff};
      ge_b     = sh_b >= {1'b0, bps_ff};
      rem_b_in = ge_b ? diff_b[BPS_W-1:0] : sh_b[BPS_W-1:0];
      quo_b_in = {quo_b_ff[NODE_W-2:0], ge_b};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rem_e_ff <= '0;
         quo_e_ff <= req_node_elements;
         rem_b_ff <= '0;
         quo_b_ff <= req_node_bytes;
      end else if (cmd.div_step) begin
         rem_e_ff <= rem_e_in;
         quo_e_ff <= quo_e_in;
         rem_b_ff <= rem_b_in;
         quo_b_ff <= quo_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_STEPS_W'(1);
      end
   end

   assign sts.div_last = &div_cnt_ff;

   // Node size delay and the new slot 2 expiry
   logic [DELAY_W-1:0] de, db, dn;
   logic [EXP_W-1:0]   exp2;

   always_comb begin
      de   = ratio_delay(quo_e_ff);
      db   = ratio_delay(quo_b_ff);
      dn   = (de > db) ? de : db;
      exp2 = now_wide + EXP_W'({dn, 1'b0});
   end

   // Throttle slots
   logic [DELAY_W-1:0] delay_ff [NSLOTS];
   logic [EXP_W-1:0]   expiry_ff [NSLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOTS; i++) begin
            delay_ff[i]  <= '0;
            expiry_ff[i] <= '0;
         end
      end else if (cmd.load_wr) begin
         delay_ff[SLOT_QUEUE]  <= d0;
         expiry_ff[SLOT_QUEUE] <= exp0;
         delay_ff[SLOT_RETRY]  <= d1;
         expiry_ff[SLOT_RETRY] <= exp1;
      end else if (cmd.node_wr) begin
         if (expiry_ff[SLOT_NODE] < now_wide || delay_ff[SLOT_NODE] < dn) begin
            delay_ff[SLOT_NODE]  <= dn;
            expiry_ff[SLOT_NODE] <= exp2;
         end
      end
   end

   // Query: largest unexpired delay, lowest slot on ties
   logic [DELAY_W-1:0] best;
   logic [SLOT_W-1:0]  win;

   always_comb begin
      best = '0;
      win  = SLOT_QUEUE;
      for (int i = 0; i < NSLOTS; i++) begin
         if (expiry_ff[i] > now_wide && best < delay_ff[i]) begin
            best = delay_ff[i];
            win  = SLOT_W'(i);
         end
      end
   end

   // Output register
   logic               rsp_valid_ff;
   logic [DELAY_W-1:0] rsp_delay_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_delay_ff <= best;
         rsp_slot_ff  <= win;
      end
   end

   assign sts.rsp_busy      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_delay = rsp_delay_ff;
   assign rsp_winning_slot  = rsp_slot_ff;

endmodule

// ===== rtl/backoff_delay_throttle.sv =====
// Split throttle with three delay slots (queue, retry, node size).
// req_ch takes one word per item, opcode selects the operation:
//   load report      - writes slots 0 and 1, no response word
//   node size report - two 32-step dividers run side by side,
//                      may replace slot 2, no response word
//   delay query      - gives a response word on rsp_ch
//   unused opcode    - accepted and dropped
// One item is worked on at a time; req_ch.ready is high only between items.
// Only a query held by rsp_ch outlasts the divide-paced node size report.
// rsp_ch is driven from an output register: a stalled response lets the
// next item be accepted and processed; only a second query waits until the
// pending response word is taken.
// csr_we/csr_index/csr_wdata write the split sizes (index 0 elements,
// index 1 bytes); the user must do so only while idle (unenforced).
// Reset (synchronous, active high) clears all slots, restores the split
// sizes to 128 and 8192 and empties the output register.
module backoff_delay_throttle #(
   parameter int TIME_BITS = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   bdt_req_if.sink                        req_ch,
   bdt_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [bdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bdt_pkg::*;

   bdt_cmd_type cmd;
   bdt_sts_type sts;

   bdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdt_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_now_ms         (req_ch.now_ms),
      .req_queue_size     (req_ch.queue_size),
      .req_split_time_avg (req_ch.split_time_avg),
      .req_retry_ms       (req_ch.retry_ms),
      .req_node_elements  (req_ch.node_elements),
      .req_node_bytes     (req_ch.node_bytes),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_current_delay  (rsp_ch.current_delay),
      .rsp_winning_slot   (rsp_ch.winning_slot)
   );

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response word valid right after reset");

   a_delay_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.current_delay <= DELAY_CAP)
      else $error("response delay above cap");

   a_zero_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.current_delay == '0 |-> rsp_ch.winning_slot == SLOT_QUEUE)
      else $error("no delay but nonzero winning slot");

   a_node_busy: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.opcode == OP_NODE |=> !req_ch.ready)
      else $error("new word taken during node size divide");
`endif

endmodule

// ===== tb/throttle_checker.sv =====
module throttle_checker (
   input  logic                           clock,
   input  logic                           reset,
   bdt_req_if                             req_ch,
   bdt_rsp_if                             rsp_ch,
   input  logic                           csr_we,
   input  logic [bdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             pending,
   output int                             replies
);
   import bdt_pkg::*;

   localparam int QUEUE_DIV     = 10;    // queue length is bucketed by tens
   localparam int QUEUE_MIN     = 5;     // fewer buckets than this gives no queue delay
   localparam int EXP_BIAS      = 4;
   localparam int RETRY_DIV     = 100;
   localparam int RETRY_MIN     = 5;
   localparam int RETRY_EXP_DIV = 100;
   localparam int RATIO_MIN     = 2;
   localparam int CAP_EXP       = 10;
   localparam int DUR_FRAC      = 9;     // split time has 8 fraction bits, then halved
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [DELAY_W-1:0] delay;
      logic [SLOT_W-1:0]  slot;
   } delay_reply_type;

   delay_reply_type    expected_replies[$];
   logic [DELAY_W-1:0] slot_delay[NSLOTS];
   logic [NOW_W:0]     slot_expiry[NSLOTS];
   logic [EPS_W-1:0]   elem_split;
   logic [BPS_W-1:0]   byte_split;

   // 2^k, saturating at the cap
   function automatic logic [DELAY_W-1:0] backoff_delay(input logic [31:0] k);
      if (k < CAP_EXP) begin
         return DELAY_W'(1) << k;
      end
      return DELAY_CAP;
   endfunction

   // node delay from count / split size; a zero divisor gives an all-ones ratio
   function automatic logic [DELAY_W-1:0] size_delay(input logic [NODE_W-1:0] count,
                                                      input logic [NODE_W-1:0] divisor);
      logic [NODE_W-1:0] ratio;
      ratio = (divisor == '0) ? '1 : count / divisor;
      if (ratio < RATIO_MIN) begin
         return '0;
      end
      return backoff_delay(ratio - RATIO_MIN);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] reply %0d mismatch: %s", $time, replies, what);
      end
   endtask

   // update the slots for one accepted word, queue a reply for a query
   task automatic predict_word();
      logic [31:0]        buckets;
      logic [31:0]        steps;
      logic [63:0]        dur;
      logic [DELAY_W-1:0] d0;
      logic [DELAY_W-1:0] d1;
      logic [DELAY_W-1:0] db;
      logic [NOW_W:0]     now;
      delay_reply_type    best;
      now = {1'b0, req_ch.now_ms};
      case (req_ch.opcode)
         OP_LOAD: begin
            buckets = 32'(req_ch.queue_size) / QUEUE_DIV;
            steps = req_ch.retry_ms / RETRY_DIV;
            d0 = '0;
            d1 = '0;
            dur = '0;
            if (buckets >= QUEUE_MIN) begin
               d0 = backoff_delay(buckets - EXP_BIAS);
               dur = (64'(req_ch.split_time_avg) * 64'(req_ch.queue_size)
                      + ((64'd1 << DUR_FRAC) - 64'd1)) >> DUR_FRAC;
            end
            if (steps >= RETRY_MIN) begin
               d1 = backoff_delay((steps - EXP_BIAS) / RETRY_EXP_DIV);
            end
            slot_delay[SLOT_QUEUE] = d0;
            slot_delay[SLOT_RETRY] = d1;
            slot_expiry[SLOT_QUEUE] = now + dur[NOW_W:0];
            slot_expiry[SLOT_RETRY] = now + {d1, 1'b0};
         end
         OP_NODE: begin
            d0 = size_delay(req_ch.node_elements, NODE_W'(elem_split));
            db = size_delay(req_ch.node_bytes, byte_split);
            if (db > d0) begin
               d0 = db;
            end
            // replace only an expired or smaller node delay
            if (slot_expiry[SLOT_NODE] < now || slot_delay[SLOT_NODE] < d0) begin
               slot_expiry[SLOT_NODE] = now + {d0, 1'b0};
               slot_delay[SLOT_NODE] = d0;
            end
         end
         OP_QUERY: begin
            best = '0;
            // strict compare keeps the lowest slot on ties
            for (int i = 0; i < NSLOTS; i++) begin
               if (slot_expiry[i] > now && best.delay < slot_delay[i]) begin
                  best.delay = slot_delay[i];
                  best.slot = SLOT_W'(i);
               end
            end
            expected_replies.push_back(best);
         end
         default: begin
            // unused opcode: dropped
         end
      endcase
   endtask

   task automatic check_reply();
      delay_reply_type want;
      replies++;
      if (expected_replies.size() == 0) begin
         note_mismatch($sformatf("unexpected word delay=%0d slot=%0d",
                                 rsp_ch.current_delay, rsp_ch.winning_slot));
      end else begin
         want = expected_replies.pop_front();
         if (rsp_ch.current_delay !== want.delay) begin
            note_mismatch($sformatf("current_delay expected %0d, got %0d",
                                    want.delay, rsp_ch.current_delay));
         end
         if (rsp_ch.winning_slot !== want.slot) begin
            note_mismatch($sformatf("winning_slot expected %0d, got %0d",
                                    want.slot, rsp_ch.winning_slot));
         end
      end
   endtask

   // everything is sampled at the rising edge; inputs move on the falling one
   always @(posedge clock) begin
      if (reset) begin
         elem_split = EPS_RESET;
         byte_split = BPS_RESET;
         for (int i = 0; i < NSLOTS; i++) begin
            slot_delay[i] = '0;
            slot_expiry[i] = '0;
         end
         expected_replies.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_reply();
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_word();
         end
         if (csr_we) begin
            if (csr_index == CSR_EPS) begin
               elem_split = csr_wdata[EPS_W-1:0];
            end else if (csr_index == CSR_BPS) begin
               byte_split = csr_wdata[BPS_W-1:0];
            end
         end
      end
      pending = expected_replies.size();
   end

endmodule

// ===== tb/backoff_delay_throttle_test.sv =====
module backoff_delay_throttle_test;
   import bdt_pkg::*;

   localparam logic [OP_W-1:0]  OP_UNUSED      = 2'd3;
   localparam logic [NOW_W-1:0] NOW_MAX        = '1;
   localparam int               IDLE_PCT       = 11;
   localparam int               PHASES         = 6;
   localparam int               PHASE_WORDS    = 100;
   localparam int               HOLD_CYCLES    = 300;
   localparam int               DRAIN_CYCLES   = 40;
   localparam int               WATCHDOG_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    pending;
   int                    replies;

   // stimulus bookkeeping
   logic                  calm;
   int                    holds_asked;
   int                    quiet_cycles;
   int                    settings;
   int                    loads;
   int                    sizes;
   int                    queries;
   int                    unused;
   logic [NOW_W-1:0]      clock_ms;
   logic [EPS_W-1:0]      elem_split;
   logic [BPS_W-1:0]      byte_split;

   bdt_req_if req_ch();
   bdt_rsp_if rsp_ch();

   backoff_delay_throttle i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   throttle_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .replies    (replies)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // reply side: random stalls, a long hold when asked, none while calm
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            holds_done++;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // one word on req_ch; entered and left at a falling edge
   task automatic send_word(input logic [OP_W-1:0]    op,
                            input logic [NOW_W-1:0]   now,
                            input logic [QUEUE_W-1:0] queue_size,
                            input logic [STA_W-1:0]   sta,
                            input logic [RETRY_W-1:0] retry,
                            input logic [NODE_W-1:0]  elements,
                            input logic [NODE_W-1:0]  bytes);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.opcode = op;
      req_ch.now_ms = now;
      req_ch.queue_size = queue_size;
      req_ch.split_time_avg = sta;
      req_ch.retry_ms = retry;
      req_ch.node_elements = elements;
      req_ch.node_bytes = bytes;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      case (op)
         OP_LOAD:  loads++;
         OP_NODE:  sizes++;
         OP_QUERY: queries++;
         default:  unused++;
      endcase
   endtask

   // wait for every reply, then for the longest word to finish
   task automatic drain();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_index = reg_index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // time mostly creeps forward, sometimes steps back or jumps anywhere
   function automatic logic [NOW_W-1:0] next_now();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) begin
         clock_ms = clock_ms + $urandom_range(0, 400);
      end else if (pick < 88) begin
         clock_ms = clock_ms - $urandom_range(0, 3000);
      end else if (pick < 95) begin
         clock_ms = NOW_W'({$urandom, $urandom});
      end else begin
         clock_ms = NOW_MAX - $urandom_range(0, 3000);
      end
      return clock_ms;
   endfunction

   // count aimed at small ratios of the divisor, so every delay step shows up
   function automatic logic [NODE_W-1:0] node_count(input logic [BPS_W-1:0] divisor);
      logic [63:0] count;
      if (divisor == '0 || $urandom_range(99) < 30) begin
         return $urandom;
      end
      count = 64'($urandom_range(0, 14)) * 64'(divisor) + 64'($urandom) % 64'(divisor);
      if (count > 64'({NODE_W{1'b1}})) begin
         return $urandom;
      end
      return count[NODE_W-1:0];
   endfunction

   task automatic send_random(input logic want_query, output logic counted);
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [QUEUE_W-1:0] queue_size;
      logic [STA_W-1:0]   sta;
      logic [RETRY_W-1:0] retry;
      pick = $urandom_range(99);
      if (want_query || pick < 40) begin
         op = OP_QUERY;
      end else if (pick < 65) begin
         op = OP_LOAD;
      end else if (pick < 95) begin
         op = OP_NODE;
      end else begin
         op = OP_UNUSED;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
         queue_size = QUEUE_W'($urandom_range(0, 160));
      end else if (pick < 70) begin
         queue_size = QUEUE_W'($urandom_range(40, 60));
      end else begin
         queue_size = QUEUE_W'($urandom);
      end
      sta = ($urandom_range(99) < 60) ? STA_W'($urandom_range(0, 20000)) : STA_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
         retry = $urandom_range(0, 1000);
      end else if (pick < 70) begin
         retry = $urandom_range(0, 110000);
      end else begin
         retry = $urandom;
      end
      send_word(op, next_now(), queue_size, sta, retry,
                node_count(BPS_W'(elem_split)), node_count(byte_split));
      counted = (op != OP_UNUSED);
   endtask

   task automatic run_random(input logic with_hold);
      int   done;
      logic counted;
      done = 0;
      while (done < PHASE_WORDS) begin
         // long reply stall while a burst of queries backs up the block
         if (with_hold && done == PHASE_WORDS / 3) begin
            holds_asked++;
            repeat (8) send_random(1'b1, counted);
            done += 8;
         end
         send_random(1'b0, counted);
         if (counted) begin
            done++;
         end
      end
   endtask

   // edges of every report and of slot expiry, at reset split sizes
   task automatic run_directed();
      send_word(OP_QUERY, '0, '0, '0, '0, '0, '0);
      send_word(OP_LOAD, '0, '0, '0, '0, '0, '0);
      send_word(OP_LOAD, 10, 49, 100, 499, '0, '0);
      send_word(OP_QUERY, 10, '0, '0, '0, '0, '0);
      send_word(OP_LOAD, 1000, 50, '1, 500, '0, '0);
      send_word(OP_QUERY, 1000, '0, '0, '0, '0, '0);
      // retry slot expires exactly now
      send_word(OP_QUERY, 1002, '0, '0, '0, '0, '0);
      send_word(OP_LOAD, 2000, '1, '1, '1, '1, '1);
      // tie at the cap goes to the lowest slot
      send_word(OP_QUERY, 2000, '1, '1, '1, '1, '1);
      send_word(OP_NODE, 2001, '0, '0, '0, '1, '1);
      send_word(OP_NODE, 2002, '0, '0, '0, '0, '0);
      send_word(OP_LOAD, 3000, '0, '0, 10399, '0, '0);
      send_word(OP_QUERY, 3000, '0, '0, '0, '0, '0);
      send_word(OP_QUERY, 4049, '0, '0, '0, '0, '0);
      // node slot ends now with a larger delay: kept
      send_word(OP_NODE, 4049, '0, '0, '0, NODE_W'(2 * EPS_RESET), '0);
      send_word(OP_NODE, 5000, '0, '0, '0, NODE_W'(2 * EPS_RESET), '0);
      send_word(OP_NODE, 5001, '0, '0, '0, NODE_W'(11 * EPS_RESET), '0);
      send_word(OP_NODE, 5002, '0, '0, '0, '0, NODE_W'(12 * BPS_RESET));
      send_word(OP_QUERY, 5002, '0, '0, '0, '0, '0);
      send_word(OP_UNUSED, NOW_W'({$urandom, $urandom}), QUEUE_W'($urandom),
                STA_W'($urandom), $urandom, $urandom, $urandom);
      // expiry past the top of the time range
      send_word(OP_LOAD, NOW_MAX, 60, 100, 10400, '0, '0);
      send_word(OP_QUERY, NOW_MAX, '0, '0, '0, '0, '0);
      send_word(OP_NODE, NOW_MAX, '0, '0, '0, NODE_W'(13 * EPS_RESET), '0);
      send_word(OP_QUERY, NOW_MAX - 1, '0, '0, '0, '0, '0);
      send_word(OP_LOAD, 6000, '0, '0, 100400, '0, '0);
      clock_ms = 6000;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] eps_word;
      logic [CSR_DATA_W-1:0] bps_word;
      reset = 1'b1;
      calm = 1'b0;
      holds_asked = 0;
      quiet_cycles = 0;
      settings = 1;
      loads = 0;
      sizes = 0;
      queries = 0;
      unused = 0;
      clock_ms = '0;
      elem_split = EPS_RESET;
      byte_split = BPS_RESET;
      csr_we = 1'b0;
      csr_index = CSR_EPS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_LOAD;
      req_ch.now_ms = '0;
      req_ch.queue_size = '0;
      req_ch.split_time_avg = '0;
      req_ch.retry_ms = '0;
      req_ch.node_elements = '0;
      req_ch.node_bytes = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_random(1'b0);

      // split sizes: minimum, maximum, zero, full random, small random
      for (int p = 1; p < PHASES; p++) begin
         drain();
         case (p)
            1: begin
               eps_word = 1;
               bps_word = 1;
            end
            2: begin
               eps_word = '1;
               bps_word = '1;
            end
            3: begin
               eps_word = '0;
               bps_word = '0;
            end
            4: begin
               eps_word = $urandom;
               bps_word = $urandom;
            end
            default: begin
               eps_word = $urandom_range(1, 300);
               bps_word = $urandom_range(1, 20000);
            end
         endcase
         // upper bits beyond the elements register are junk
         eps_word[CSR_DATA_W-1:EPS_W] = (CSR_DATA_W - EPS_W)'($urandom);
         write_reg(CSR_EPS, eps_word);
         write_reg(CSR_BPS, bps_word);
         elem_split = eps_word[EPS_W-1:0];
         byte_split = bps_word[BPS_W-1:0];
         settings++;
         calm = (p == 3);
         run_random(p == 2);
      end
      calm = 1'b0;
      drain();

      $display("Checked %0d replies, %0d words: %0d load, %0d size, %0d query, %0d unused.",
               replies, loads + sizes + queries + unused, loads, sizes, queries, unused);
      $display("%0d split size settings incl. one, all-ones and zero; %0d long reply stalls.",
               settings, holds_asked);
      if (mismatches == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bdt_pkg.sv
rtl/bdt_ifs.sv
rtl/bdt_ctrl.sv
rtl/bdt_dp.sv
rtl/backoff_delay_throttle.sv
tb/throttle_checker.sv
tb/backoff_delay_throttle_test.sv
